// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. The bodies are empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/krp_pkg.sv
// ---------------------------------------------------------------------------
// krp_pkg
// Types and constants shared by the key record parser modules.
// ---------------------------------------------------------------------------
package krp_pkg;

	localparam int MAX_NUMBER_BYTES  = 10;
	localparam int FIXED_FIELD_BYTES = 10;
	localparam int NB_CNT_W          = $clog2(MAX_NUMBER_BYTES + 1);

	localparam logic [15:0] MAX_KEY_LENGTH_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_NUMBER    = 3'd0,
		PH_EFFECTIVE = 3'd1,
		PH_ASSERTION = 3'd2,
		PH_LENGTH    = 3'd3,
		PH_KEY       = 3'd4,
		PH_SKIP      = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_KEY    = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_KEY_LONG  = 3'd2,
		ERR_TRUNCATED = 3'd3,
		ERR_OVERFLOW  = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] bytes_left;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] node_number;
		logic [31:0] effective_time;
		logic [31:0] assertion_time;
		logic [15:0] key_length;
		logic [7:0]  key_byte;
		err_t        error_code;
		logic        record_last;
		logic [15:0] record_length;
	} result_t;

	// Result handed from the parse stage to the result register
	typedef struct packed {
		logic    load;
		result_t data;
	} res_load_t;

endpackage

// File: src/key_record_parser_top.sv
// ---------------------------------------------------------------------------
// key_record_parser_top
// Byte-serial key record parser: SDNV node number, times, key length, key bytes.
// ---------------------------------------------------------------------------
// The parser takes one buffer byte per clock cycle and gives at most one result
// per byte: the byte sits in the input register, then the parse stage updates
// the record fields and loads the result register, which presents the result.
// Sustained rate is one item per cycle as long as results are taken; a stalled
// result holds the parse stage and, once the input register is full, the input.
// max_key_length (reset 65535) is written through the cfg port, always ready,
// and should only change while the parser is idle.
// After an error the parser drops bytes through the end of the current buffer.
module key_record_parser_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  krp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output krp_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	import krp_pkg::*;

	`include "assert_macros.svh"

	logic      valid_s1;
	item_t     item_s1;
	logic      advance;
	logic      out_free;
	res_load_t res;

	assign cfg_ready = 1'b1;

	krp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	krp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res       (res)
	);

	krp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`ASSERT_IMPLY(a_load_needs_item, clk, arst_n, res.load, advance,
		"result loaded without an item in the parse stage")
	`ASSERT_NEXT(a_load_shows_result, clk, arst_n, res.load, result_valid,
		"loaded result not presented")
	`ASSERT_IMPLY(a_error_ends_record, clk, arst_n,
		res.load && res.data.kind == KIND_ERROR,
		res.data.record_last && res.data.record_length == 16'd0,
		"error result must close the record with zero length")
	`ASSERT_NEXT(a_input_moves, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(item_s1), "held item lost in input register")

endmodule

// File: src/krp_in_reg.sv
// ---------------------------------------------------------------------------
// krp_in_reg
// Input register: holds one accepted item for the parse stage.
// ---------------------------------------------------------------------------
module krp_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  krp_pkg::item_t item,
	input  logic          advance,
	output logic          valid_s1,
	output krp_pkg::item_t item_s1
);
	import krp_pkg::*;

	logic  valid_s1_q;
	item_t item_s1_q;

	// refill in the same cycle the held item moves on
	assign item_ready = !valid_s1_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1_q <= 1'b1;
		end else if (advance) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1_q <= item;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign item_s1  = item_s1_q;

endmodule

// File: src/krp_parse_core.sv
// ---------------------------------------------------------------------------
// krp_parse_core
// Record state and per-byte field update; produces at most one result per item.
// ---------------------------------------------------------------------------
module krp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  logic               valid_s1,
	input  krp_pkg::item_t     item_s1,
	input  logic               out_free,
	output logic               advance,
	output krp_pkg::res_load_t res
);
	import krp_pkg::*;

	phase_t              phase_q, phase_d;
	logic [63:0]         acc_q, acc_d;
	logic [NB_CNT_W-1:0] nb_cnt_q, nb_cnt_d;
	logic [31:0]         eff_q, eff_d;
	logic [31:0]         asr_q, asr_d;
	logic [15:0]         len_q, len_d;
	logic [1:0]          idx_q, idx_d;
	logic [15:0]         key_left_q, key_left_d;
	logic [15:0]         consumed_q, consumed_d;
	logic [15:0]         max_key_q;

	logic [7:0]          b;
	logic [15:0]         left;
	logic                at_end;
	logic [15:0]         consumed_inc;
	logic [15:0]         len_shift;
	logic [15:0]         key_dec;
	logic [NB_CNT_W-1:0] nb_inc;
	logic                raise;
	err_t                err_code;
	logic                err_at_end;
	logic                new_rec;

	assign advance      = valid_s1 && out_free;
	assign b            = item_s1.data_byte;
	assign left         = item_s1.bytes_left;
	assign at_end       = (left <= 16'd1);
	assign consumed_inc = consumed_q + 16'd1;
	assign len_shift    = {len_q[7:0], b};
	assign key_dec      = key_left_q - 16'd1;
	assign nb_inc       = nb_cnt_q + NB_CNT_W'(1);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		nb_cnt_d   = nb_cnt_q;
		eff_d      = eff_q;
		asr_d      = asr_q;
		len_d      = len_q;
		idx_d      = idx_q;
		key_left_d = key_left_q;
		consumed_d = consumed_inc;
		raise      = 1'b0;
		err_code   = ERR_NONE;
		err_at_end = 1'b0;
		new_rec    = 1'b0;
		res.load   = 1'b0;
		res.data   = '0;

		unique case (phase_q)
			PH_SKIP: begin
				consumed_d = consumed_q;
				new_rec    = at_end;
			end
			PH_EFFECTIVE, PH_ASSERTION: begin
				if (phase_q == PH_EFFECTIVE) begin
					eff_d = {eff_q[23:0], b};
				end else begin
					asr_d = {asr_q[23:0], b};
				end
				if (at_end) begin
					raise      = 1'b1;
					err_code   = ERR_SHORT;
					err_at_end = 1'b1;
				end else if (idx_q == 2'd3) begin
					idx_d   = 2'd0;
					phase_d = (phase_q == PH_EFFECTIVE) ? PH_ASSERTION : PH_LENGTH;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			PH_LENGTH: begin
				len_d = len_shift;
				if (idx_q == 2'd0) begin
					if (at_end) begin
						raise      = 1'b1;
						err_code   = ERR_SHORT;
						err_at_end = 1'b1;
					end else begin
						idx_d = 2'd1;
					end
				end else begin
					idx_d = 2'd0;
					if (len_shift > max_key_q) begin
						raise      = 1'b1;
						err_code   = ERR_KEY_LONG;
						err_at_end = at_end;
					end else if (len_shift != 16'd0 && left <= len_shift) begin
						raise      = 1'b1;
						err_code   = ERR_TRUNCATED;
						err_at_end = at_end;
					end else begin
						res.load                = 1'b1;
						res.data.kind           = KIND_HEADER;
						res.data.node_number    = acc_q;
						res.data.effective_time = eff_q;
						res.data.assertion_time = asr_q;
						res.data.key_length     = len_shift;
						if (len_shift == 16'd0) begin
							res.data.record_last   = 1'b1;
							res.data.record_length = consumed_inc;
							new_rec                = 1'b1;
						end else begin
							key_left_d = len_shift;
							phase_d    = PH_KEY;
						end
					end
				end
			end
			PH_KEY: begin
				key_left_d = key_dec;
				if (key_dec == 16'd0) begin
					res.load               = 1'b1;
					res.data.kind          = KIND_KEY;
					res.data.key_byte      = b;
					res.data.record_last   = 1'b1;
					res.data.record_length = consumed_inc;
					new_rec                = 1'b1;
				end else if (at_end) begin
					raise      = 1'b1;
					err_code   = ERR_TRUNCATED;
					err_at_end = 1'b1;
				end else begin
					res.load          = 1'b1;
					res.data.kind     = KIND_KEY;
					res.data.key_byte = b;
				end
			end
			default: begin
				// number phase: 7 value bits per byte, top bit continues
				acc_d    = {acc_q[56:0], b[6:0]};
				nb_cnt_d = nb_inc;
				if (b[7]) begin
					if (nb_inc >= NB_CNT_W'(MAX_NUMBER_BYTES)) begin
						raise      = 1'b1;
						err_code   = ERR_OVERFLOW;
						err_at_end = at_end;
					end else if (at_end) begin
						raise      = 1'b1;
						err_code   = ERR_SHORT;
						err_at_end = 1'b1;
					end
				end else if (left <= 16'(FIXED_FIELD_BYTES)) begin
					raise      = 1'b1;
					err_code   = ERR_SHORT;
					err_at_end = at_end;
				end else begin
					phase_d = PH_EFFECTIVE;
					idx_d   = 2'd0;
					eff_d   = '0;
					asr_d   = '0;
					len_d   = '0;
				end
			end
		endcase

		if (raise) begin
			res.load             = 1'b1;
			res.data             = '0;
			res.data.kind        = KIND_ERROR;
			res.data.error_code  = err_code;
			res.data.record_last = 1'b1;
			new_rec              = 1'b1;
		end

		if (new_rec) begin
			phase_d    = PH_NUMBER;
			acc_d      = '0;
			nb_cnt_d   = '0;
			idx_d      = 2'd0;
			key_left_d = '0;
			consumed_d = '0;
		end
		// drop the rest of the buffer after a mid-buffer error
		if (raise && !err_at_end) begin
			phase_d = PH_SKIP;
		end

		if (!advance) begin
			res.load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NUMBER;
			acc_q      <= '0;
			nb_cnt_q   <= '0;
			eff_q      <= '0;
			asr_q      <= '0;
			len_q      <= '0;
			idx_q      <= 2'd0;
			key_left_q <= '0;
			consumed_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			nb_cnt_q   <= nb_cnt_d;
			eff_q      <= eff_d;
			asr_q      <= asr_d;
			len_q      <= len_d;
			idx_q      <= idx_d;
			key_left_q <= key_left_d;
			consumed_q <= consumed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_q <= MAX_KEY_LENGTH_RESET;
		end else if (cfg_valid) begin
			max_key_q <= cfg_data;
		end
	end

endmodule

// File: src/krp_out_reg.sv
// ---------------------------------------------------------------------------
// krp_out_reg
// Result register: holds one result item until the consumer takes it.
// ---------------------------------------------------------------------------
module krp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  krp_pkg::res_load_t res,
	output logic               out_free,
	output logic               result_valid,
	input  logic               result_ready,
	output krp_pkg::result_t   result
);
	import krp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign out_free = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			data_q <= res.data;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule
